FILE: sv/bpc_pkg.sv
// Shared types and constants for the pair-frequency counter.
// Used by bpc_ctrl, bpc_dpath and bpe_pair_count_argmax; depends on nothing.
package bpc_pkg;

  localparam int VOCAB_IDS_DEF  = 256;
  localparam int COUNT_BITS_DEF = 24;
  localparam int ID_W           = 8;
  localparam int OUT_COUNT_W    = 24;
  localparam int MERGE_MIN      = 2;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic REG_NEWLINE_ID     = 1'b0;
  localparam logic REG_NEWLINE_ENABLE = 1'b1;

  typedef struct packed {
    logic latch;
    logic clear_step;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

FILE: sv/bpc_ctrl.sv
// Controller state machine of the pair-frequency counter.
// Depends on bpc_pkg; drives the command word of bpc_dpath.
module bpc_ctrl
  import bpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       round_start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_UPDATE
  } state_t;

  state_t state;
  logic   have_item;

  always_comb begin
    cmd.latch      = (state == S_IDLE) && start;
    cmd.clear_step = (state == S_CLEAR);
    cmd.update     = (state == S_UPDATE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      have_item <= 1'b0;
      busy      <= 1'b1;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            have_item <= 1'b1;
            busy      <= 1'b1;
            state     <= round_start ? S_CLEAR : S_READ;
          end
        end
        S_CLEAR: begin
          if (status.clear_last) begin
            state <= have_item ? S_READ : S_IDLE;
            busy  <= have_item;
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          state     <= S_IDLE;
          have_item <= 1'b0;
          busy      <= 1'b0;
          done      <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: sv/bpc_dpath.sv
// Datapath of the pair-frequency counter: pair table, previous token and best pair.
// Depends on bpc_pkg; commanded by bpc_ctrl.
module bpc_dpath
  import bpc_pkg::*;
#(
  parameter int VOCAB_IDS  = VOCAB_IDS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic [ID_W-1:0]        token_id,
  input  logic                   token_usable,
  input  logic [ID_W-1:0]        newline_id,
  input  logic                   newline_enable,
  output logic [ID_W-1:0]        best_first,
  output logic [ID_W-1:0]        best_second,
  output logic [OUT_COUNT_W-1:0] best_freq,
  output logic                   worth_merging
);

  localparam int TABLE_IDS = (VOCAB_IDS < (1 << ID_W)) ? VOCAB_IDS : (1 << ID_W);
  localparam int IDX_W     = $clog2(TABLE_IDS);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = 1 << ADDR_W;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rdata;

  logic [ID_W-1:0]       cur_token;
  logic                  cur_usable;
  logic [ID_W-1:0]       prev_token;
  logic                  prev_present;
  logic                  prev_usable;
  logic [ID_W-1:0]       best_a;
  logic [ID_W-1:0]       best_b;
  logic [COUNT_BITS-1:0] best_total;
  logic [ADDR_W-1:0]     clr_addr;

  logic [ADDR_W-1:0]     pair_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  wr_en;
  logic                  pair_ok;
  logic                  is_break;
  logic [COUNT_BITS-1:0] count_next;

  assign pair_addr = {prev_token[IDX_W-1:0], cur_token[IDX_W-1:0]};
  assign pair_ok   = prev_present && prev_usable && cur_usable;
  assign is_break  = pair_ok && newline_enable && (cur_token == newline_id);
  assign count_next = (&rdata) ? rdata : rdata + COUNT_BITS'(1);

  assign wr_en   = cmd.clear_step || (cmd.update && pair_ok && !is_break);
  assign wr_addr = cmd.clear_step ? clr_addr : pair_addr;
  assign wr_data = cmd.clear_step ? '0 : count_next;

  assign status.clear_last = &clr_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[pair_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur_token  <= token_id;
      cur_usable <= token_usable && (32'(token_id) < VOCAB_IDS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      prev_token   <= '0;
      prev_present <= 1'b0;
      prev_usable  <= 1'b0;
      best_a       <= '0;
      best_b       <= '0;
      best_total   <= '0;
    end else if (cmd.clear_step) begin
      clr_addr     <= clr_addr + ADDR_W'(1);
      prev_token   <= '0;
      prev_present <= 1'b0;
      prev_usable  <= 1'b0;
      best_a       <= '0;
      best_b       <= '0;
      best_total   <= '0;
    end else if (cmd.update) begin
      if (is_break) begin
        prev_token   <= '0;
        prev_present <= 1'b0;
        prev_usable  <= 1'b0;
      end else begin
        if (pair_ok && (count_next > best_total)) begin
          best_total <= count_next;
          best_a     <= prev_token;
          best_b     <= cur_token;
        end
        prev_token   <= cur_token;
        prev_present <= 1'b1;
        prev_usable  <= cur_usable;
      end
    end
  end

  generate
    if (COUNT_BITS >= OUT_COUNT_W) begin : g_cnt_trunc
      assign best_freq = best_total[OUT_COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign best_freq = {{(OUT_COUNT_W-COUNT_BITS){1'b0}}, best_total};
    end
  endgenerate

  assign best_first    = best_a;
  assign best_second   = best_b;
  assign worth_merging = (best_total >= COUNT_BITS'(MERGE_MIN));

endmodule

FILE: sv/bpe_pair_count_argmax.sv
// Top level of the pair-frequency counter: configuration registers and the two halves.
// Depends on bpc_pkg, bpc_ctrl and bpc_dpath.
// A word is taken when start is high and busy is low; it passes through the read and update
// states and its result then strobes on done; busy stays high until then, so no new word is taken.
// With round_start the table of (min(VOCAB_IDS,256) rounded up to a power of two)^2 entries
// is first swept one entry a cycle; the same sweep runs after reset with busy high.
module bpe_pair_count_argmax
  import bpc_pkg::*;
#(
  parameter int VOCAB_IDS  = VOCAB_IDS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  output logic                   done,
  input  logic                   round_start,
  input  logic [ID_W-1:0]        token_id,
  input  logic                   token_usable,
  output logic [ID_W-1:0]        best_first,
  output logic [ID_W-1:0]        best_second,
  output logic [OUT_COUNT_W-1:0] best_freq,
  output logic                   worth_merging
);

  logic [ID_W-1:0] newline_id;
  logic            newline_enable;
  logic            reg_sel;
  dp_cmd_t         cmd;
  dp_status_t      status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      newline_id     <= '0;
      newline_enable <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_NEWLINE_ID:     newline_id     <= pwdata[ID_W-1:0];
        REG_NEWLINE_ENABLE: newline_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NEWLINE_ID:     prdata = {{(CFG_DATA_W-ID_W){1'b0}}, newline_id};
      REG_NEWLINE_ENABLE: prdata = {{(CFG_DATA_W-1){1'b0}}, newline_enable};
      default:            prdata = '0;
    endcase
  end

  bpc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .round_start (round_start),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy),
    .done        (done)
  );

  bpc_dpath #(
    .VOCAB_IDS  (VOCAB_IDS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .token_id       (token_id),
    .token_usable   (token_usable),
    .newline_id     (newline_id),
    .newline_enable (newline_enable),
    .best_first     (best_first),
    .best_second    (best_second),
    .best_freq      (best_freq),
    .worth_merging  (worth_merging)
  );

endmodule

FILE: test/tb_bpe_pair_count_argmax.sv
`timescale 1ns / 1ps
// Self-checking testbench for bpe_pair_count_argmax: drives token words and register writes,
// predicts the best pair after every word and compares each done word. Depends on bpc_pkg.

typedef struct packed {
  logic [7:0]  first;
  logic [7:0]  second;
  logic [23:0] count;
  logic        merge;
} best_word_t;

class pair_tally_board;
  bit [23:0]  tally [65536];
  bit [7:0]   last_id;
  bit         last_seen;
  bit         last_ok;
  bit [15:0]  top_pair;
  bit [23:0]  top_count;
  bit [7:0]   nl_id;
  bit         nl_on;
  best_word_t awaited [$];
  int         mismatches;

  function new();
    wipe_round();
    nl_id = 0;
    nl_on = 0;
    mismatches = 0;
  endfunction

  function void wipe_round();
    foreach (tally[i]) tally[i] = 0;
    last_id = 0;
    last_seen = 0;
    last_ok = 0;
    top_pair = 0;
    top_count = 0;
  endfunction

  function void write_reg(logic idx, logic [31:0] val);
    if (idx == bpc_pkg::REG_NEWLINE_ID) nl_id = val[7:0];
    else if (idx == bpc_pkg::REG_NEWLINE_ENABLE) nl_on = val[0];
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function void note_word(logic rs, logic [7:0] id, logic ok);
    bit         cur_ok;
    bit [15:0]  slot;
    bit [23:0]  c;
    best_word_t w;
    cur_ok = ok && (int'(id) < bpc_pkg::VOCAB_IDS_DEF);
    if (rs) wipe_round();
    if (last_seen && last_ok && cur_ok && nl_on && id == nl_id) begin
      // An enabled, usable newline right after a usable token breaks the chain.
      last_seen = 0;
      last_ok = 0;
      last_id = 0;
    end else begin
      if (last_seen && last_ok && cur_ok) begin
        slot = {last_id, id};
        c = tally[slot];
        if (c != 24'hFFFFFF) c = c + 24'd1;
        tally[slot] = c;
        if (c > top_count) begin
          top_count = c;
          top_pair = slot;
        end
      end
      last_id = id;
      last_seen = 1;
      last_ok = cur_ok;
    end
    w.first = top_pair[15:8];
    w.second = top_pair[7:0];
    w.count = top_count;
    w.merge = (top_count >= bpc_pkg::MERGE_MIN);
    awaited.push_back(w);
  endfunction

  function void check_word(best_word_t got);
    best_word_t exp;
    if (awaited.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected word: first=%0d second=%0d count=%0d merge=%0d",
                 got.first, got.second, got.count, got.merge);
      mismatches++;
      return;
    end
    exp = awaited.pop_front();
    if (got.first !== exp.first || got.second !== exp.second ||
        got.count !== exp.count || got.merge !== exp.merge) begin
      if (mismatches < 10)
        $display("mismatch: exp first=%0d second=%0d count=%0d merge=%0d, got %0d %0d %0d %0d",
                 exp.first, exp.second, exp.count, exp.merge,
                 got.first, got.second, got.count, got.merge);
      mismatches++;
    end
  endfunction
endclass

module tb_bpe_pair_count_argmax;
  import bpc_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_ADDR_W-1:0]  paddr;
  logic [CFG_DATA_W-1:0]  pwdata;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   start;
  logic                   busy;
  logic                   done;
  logic                   round_start;
  logic [ID_W-1:0]        token_id;
  logic                   token_usable;
  logic [ID_W-1:0]        best_first;
  logic [ID_W-1:0]        best_second;
  logic [OUT_COUNT_W-1:0] best_freq;
  logic                   worth_merging;

  pair_tally_board sb;
  int              cycles;

  bpe_pair_count_argmax dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .done(done),
    .round_start(round_start), .token_id(token_id), .token_usable(token_usable),
    .best_first(best_first), .best_second(best_second),
    .best_freq(best_freq), .worth_merging(worth_merging)
  );

  initial clk = 0;
  always #1 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_word({best_first, best_second, best_freq, worth_merging});
  end

  task reg_write(input logic idx, input logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, val);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  task send_word(input logic rs, input logic [7:0] id, input logic ok);
    start <= 1;
    round_start <= rs;
    token_id <= id;
    token_usable <= ok;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(rs, id, ok);
  endtask

  task drain();
    start <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task random_phase(input int count, input int idle_pct);
    logic [7:0] pool [6];
    int         restart_at;
    logic       rs;
    logic [7:0] id;
    logic       ok;
    bit         calm;
    pool[0] = sb.nl_id;
    for (int k = 1; k < 6; k++) pool[k] = 8'($urandom);
    restart_at = $urandom_range(count - 1, count / 4);
    for (int n = 0; n < count; n++) begin
      rs = (n == 0 || n == restart_at);
      if ($urandom_range(99) < 75) id = pool[$urandom_range(5)];
      else id = 8'($urandom);
      ok = ($urandom_range(99) < 90);
      send_word(rs, id, ok);
      calm = ((n / 64) % 4 == 3);
      if ($urandom_range(99) == 0) begin
        start <= 0;
        while (sb.pending() != 0) @(posedge clk);
      end else if (!calm && $urandom_range(99) < idle_pct) begin
        start <= 0;
        do @(posedge clk); while ($urandom_range(99) < idle_pct);
      end
    end
  endtask

  initial begin
    sb = new();
    rst <= 1;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= '0;
    pwdata <= '0;
    start <= 0;
    round_start <= 0;
    token_id <= '0;
    token_usable <= 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    reg_write(REG_NEWLINE_ID, 32'd10);
    reg_write(REG_NEWLINE_ENABLE, 32'd1);

    // Pairs at the id extremes, a tie, then a strict new best.
    send_word(1, 8'd0, 1);
    send_word(0, 8'd0, 1);
    send_word(0, 8'd255, 1);
    send_word(0, 8'd255, 1);
    send_word(0, 8'd0, 1);
    send_word(0, 8'd255, 1);
    // Newline handling and marker tokens.
    send_word(0, 8'd10, 1);
    send_word(0, 8'd10, 1);
    send_word(0, 8'd5, 1);
    send_word(0, 8'd7, 0);
    send_word(0, 8'd5, 1);
    send_word(0, 8'd10, 1);
    send_word(0, 8'd10, 0);
    send_word(0, 8'd10, 1);
    send_word(0, 8'd10, 1);
    // A new round in mid-stream, starting on a marker token.
    send_word(1, 8'hAA, 0);
    send_word(0, 8'hAA, 1);
    send_word(0, 8'h55, 1);
    send_word(0, 8'hAA, 1);
    send_word(0, 8'h55, 1);
    send_word(0, 8'hAA, 1);
    send_word(0, 8'h55, 1);
    drain();

    reg_write(REG_NEWLINE_ID, 32'd0);
    reg_write(REG_NEWLINE_ENABLE, 32'd1);
    random_phase(430, 18);
    drain();

    reg_write(REG_NEWLINE_ID, 32'd255);
    random_phase(430, 48);
    drain();

    reg_write(REG_NEWLINE_ID, 32'h5A);
    reg_write(REG_NEWLINE_ENABLE, 32'd0);
    random_phase(430, 0);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
